/* design/dwzn_pkg.sv */
// Shared constants and types of the decimating window z-score normaliser.
package dwzn_pkg;

    localparam int WIN_LEN   = 256;
    localparam int WIN_AW    = 8;
    localparam int MAX_BATCH = 16;
    localparam int MAX_DEC   = 255;
    localparam int BATCH_SAT = 511;

    typedef enum logic {
        MODE_DIV  = 1'b0,
        MODE_SQRT = 1'b1
    } unit_mode_t;

    typedef struct packed {
        logic       start;
        unit_mode_t mode;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* design/dwzn_shift_sub.sv */
// Shared shift-and-subtract unit: restoring division or restoring square root, one bit a cycle.
module dwzn_shift_sub (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dwzn_pkg::unit_req_t    req,
    input  logic [63:0]            opa,
    input  logic [33:0]            opb,
    output dwzn_pkg::unit_stat_t   stat,
    output logic [63:0]            result
);

    logic                  busy_reg;
    logic                  done_reg;
    dwzn_pkg::unit_mode_t  mode_reg;
    logic [6:0]            step_reg;
    logic [63:0]           src_reg;
    logic [35:0]           rem_reg;
    logic [63:0]           q_reg;
    logic [33:0]           div_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    logic        last_step;

    always_comb begin
        if (mode_reg == dwzn_pkg::MODE_SQRT) begin
            rem_sh    = {rem_reg[33:0], src_reg[63:62]};
            trial     = {q_reg[33:0], 2'b01};
            last_step = (step_reg == 7'd31);
        end else begin
            rem_sh    = {rem_reg[34:0], src_reg[63]};
            trial     = {2'b00, div_reg};
            last_step = (step_reg == 7'd63);
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                step_reg <= 7'd0;
                src_reg  <= opa;
                div_reg  <= opb;
                rem_reg  <= 36'd0;
                q_reg    <= 64'd0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff : rem_sh;
                q_reg    <= {q_reg[62:0], ge};
                src_reg  <= (mode_reg == dwzn_pkg::MODE_SQRT) ? {src_reg[61:0], 2'b00}
                                                               : {src_reg[62:0], 1'b0};
                step_reg <= step_reg + 7'd1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = q_reg;

endmodule

/* design/dwzn_window_store.sv */
// Circular window memory with per-entry valid bits; an unwritten entry reads as its ramp value.
module dwzn_window_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [dwzn_pkg::WIN_AW-1:0]   wr_addr,
    input  logic [23:0]                   wr_data,
    input  logic                          rd_en,
    input  logic [dwzn_pkg::WIN_AW-1:0]   rd_addr,
    output logic [23:0]                   rd_data
);

    logic [23:0]                  mem [dwzn_pkg::WIN_LEN];
    logic [dwzn_pkg::WIN_LEN-1:0] valid_reg;
    logic [23:0]                  rd_q_reg;
    logic                         rd_hit_reg;
    logic [dwzn_pkg::WIN_AW-1:0]  rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_q_reg
                                : {{(16 - dwzn_pkg::WIN_AW){1'b0}}, rd_addr_reg, 8'h00};

endmodule

/* design/decimating_window_zscore_normalizer.sv */
// Top level of the decimating window z-score normaliser.
// Each sample word is added to a running sum; once 'decimation' samples have been taken
// the sum, scaled to 16.8 fixed point, is divided by the decimation value and the record
// is written into a 256-entry circular window (which holds the ramp 0,1,2,... after
// reset). A sample word marked with s_tlast ends a batch; if the batch completed any
// records, the window mean and sample standard deviation are computed and the newest
// records of the batch (at most 16) are sent out, oldest first, with their z-scores in
// signed Q6.10, the final one marked with m_tlast; m_tuser is set on every word of the batch
// when records were dropped. Division by a variable and the square root run on one shared
// shift-subtract unit, and the squared-deviation sum is divided by 255 by folding it in
// base 256, one step a cycle. The block therefore takes one word at a time: an ordinary
// sample leaves the input ready, one that completes a record waits for the 64-step divider,
// and a batch end also waits for the two 256-entry walks of the window memory, the square
// root and one division per result word, each result word being held until the receiver
// is ready. There is no clearing pass: reset marks every window entry as holding its ramp
// value at once.
module decimating_window_zscore_normalizer (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] sample
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [23:0] raw_average, [40:24] normalized, [48:41] position, [55:49] zero
    output logic [55:0] m_tdata,
    // m_tuser: [0] dropped
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_AVG  = 10'b0000000010,
        ST_SUM  = 10'b0000000100,
        ST_SSD  = 10'b0000001000,
        ST_VAR  = 10'b0000010000,
        ST_SQRT = 10'b0000100000,
        ST_RD   = 10'b0001000000,
        ST_RDW  = 10'b0010000000,
        ST_ZDIV = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } state_t;

    state_t                       state_reg;
    logic [7:0]                   dec_reg;
    logic [23:0]                  sum_reg;
    logic [7:0]                   cnt_reg;
    logic [dwzn_pkg::WIN_AW-1:0]  slot_reg;
    logic [8:0]                   recs_reg;
    logic                         be_reg;
    logic [8:0]                   walk_reg;
    logic                         rdv_reg;
    logic [32:0]                  total_reg;
    logic [24:0]                  mean_reg;
    logic [49:0]                  prod_reg;
    logic                         prodv_reg;
    logic [63:0]                  ssd_reg;
    logic [63:0]                  vquo_reg;
    logic [31:0]                  sd_reg;
    logic [4:0]                   n_reg;
    logic [4:0]                   k_reg;
    logic                         drop_reg;
    logic                         neg_reg;
    logic [dwzn_pkg::WIN_AW-1:0]  pos_reg;
    logic [23:0]                  x_reg;
    logic                         start_reg;
    dwzn_pkg::unit_mode_t         mode_reg;
    logic [63:0]                  opa_reg;
    logic [33:0]                  opb_reg;
    logic                         mvalid_reg;
    logic [23:0]                  oavg_reg;
    logic [16:0]                  oz_reg;
    logic [7:0]                   opos_reg;
    logic                         olast_reg;
    logic                         odrop_reg;

    dwzn_pkg::unit_req_t          req;
    dwzn_pkg::unit_stat_t         stat;
    logic [63:0]                  result;

    logic                         wr_en;
    logic [23:0]                  wr_data;
    logic                         rd_en;
    logic [dwzn_pkg::WIN_AW-1:0]  rd_addr;
    logic [23:0]                  rd_data;

    logic [23:0]                  sum_next;
    logic [7:0]                   cnt_next;
    logic                         s_acc;
    logic signed [25:0]           dev;
    logic [24:0]                  mag;
    logic [63:0]                  var_q;
    logic [47:0]                  var_sel;
    logic [dwzn_pkg::WIN_AW-1:0]  rec_addr;
    logic [16:0]                  z_val;

    assign req.start = start_reg;
    assign req.mode  = mode_reg;

    dwzn_shift_sub u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opa     (opa_reg),
        .opb     (opb_reg),
        .stat    (stat),
        .result  (result)
    );

    dwzn_window_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign sum_next  = sum_reg + {8'h00, s_tdata};
    assign cnt_next  = cnt_reg + 8'd1;

    // The record write happens on the cycle the divider finishes; the average saturates.
    assign wr_en   = (state_reg == ST_AVG) && stat.done;
    assign wr_data = (result[63:24] != 40'd0) ? 24'hFFFFFF : result[23:0];

    // Records of the batch sit just behind the write slot, oldest first.
    assign rec_addr = slot_reg - dwzn_pkg::WIN_AW'(n_reg) + dwzn_pkg::WIN_AW'(k_reg);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = walk_reg[dwzn_pkg::WIN_AW-1:0];
        if ((state_reg == ST_SUM || state_reg == ST_SSD) && !walk_reg[8]) begin
            rd_en = 1'b1;
        end else if (state_reg == ST_RD) begin
            rd_en   = 1'b1;
            rd_addr = rec_addr;
        end
    end

    // Deviation of the entry just read from the window mean, and its magnitude.
    assign dev     = $signed({2'b00, rd_data}) - $signed({1'b0, mean_reg});
    assign mag     = dev[25] ? 25'(-dev) : dev[24:0];
    // Once the folded remainder is below 256 it only adds one more when it equals 255.
    assign var_q   = vquo_reg + {63'd0, (ssd_reg[7:0] == 8'hFF)};
    // A zero variance is lifted to one LSB.
    assign var_sel = (var_q == 64'd0) ? 48'd1 : var_q[47:0];

    always_comb begin
        if (neg_reg) begin
            z_val = (result > 64'd65536) ? 17'h10000 : 17'd0 - result[16:0];
        end else begin
            z_val = (result > 64'd65535) ? 17'h0FFFF : result[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dec_reg    <= 8'd1;
            sum_reg    <= 24'd0;
            cnt_reg    <= 8'd0;
            slot_reg   <= '0;
            recs_reg   <= 9'd0;
            start_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
            rdv_reg    <= 1'b0;
            prodv_reg  <= 1'b0;
            walk_reg   <= 9'd0;
        end else begin
            start_reg <= 1'b0;
            rdv_reg   <= rd_en;
            prodv_reg <= 1'b0;

            if (cfg_valid && cfg_ready) begin
                dec_reg <= (cfg_data == 8'd0 || cfg_data > 8'(dwzn_pkg::MAX_DEC)) ? 8'd1
                                                                                   : cfg_data;
            end

            if (rd_en) begin
                walk_reg <= walk_reg + 9'd1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        be_reg <= s_tlast;
                        if (cnt_next >= dec_reg) begin
                            opa_reg   <= {32'd0, sum_next, 8'h00};
                            opb_reg   <= {26'd0, dec_reg};
                            mode_reg  <= dwzn_pkg::MODE_DIV;
                            start_reg <= 1'b1;
                            state_reg <= ST_AVG;
                        end else begin
                            sum_reg <= sum_next;
                            cnt_reg <= cnt_next;
                            if (s_tlast && recs_reg != 9'd0) begin
                                walk_reg  <= 9'd0;
                                total_reg <= 33'd0;
                                state_reg <= ST_SUM;
                            end
                        end
                    end
                end
                ST_AVG: begin
                    if (stat.done) begin
                        slot_reg <= slot_reg + 1'b1;
                        if (recs_reg != 9'(dwzn_pkg::BATCH_SAT)) begin
                            recs_reg <= recs_reg + 9'd1;
                        end
                        sum_reg <= 24'd0;
                        cnt_reg <= 8'd0;
                        if (be_reg) begin
                            walk_reg  <= 9'd0;
                            total_reg <= 33'd0;
                            state_reg <= ST_SUM;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SUM: begin
                    if (rdv_reg) begin
                        total_reg <= total_reg + {9'd0, rd_data};
                    end
                    if (walk_reg[8] && !rdv_reg) begin
                        mean_reg  <= total_reg[32:8];
                        walk_reg  <= 9'd0;
                        ssd_reg   <= 64'd0;
                        state_reg <= ST_SSD;
                    end
                end
                ST_SSD: begin
                    // Square registered before it is summed.
                    prod_reg  <= mag * mag;
                    prodv_reg <= rdv_reg;
                    if (prodv_reg) begin
                        ssd_reg <= ssd_reg + {14'd0, prod_reg};
                    end
                    if (walk_reg[8] && !rdv_reg && !prodv_reg) begin
                        vquo_reg  <= 64'd0;
                        state_reg <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    // Division by 255: with x = 256a + b, x / 255 = a + (a + b) / 255,
                    // so the high part is added to the quotient and folded back each cycle.
                    if (ssd_reg[63:8] != 56'd0) begin
                        vquo_reg <= vquo_reg + {8'd0, ssd_reg[63:8]};
                        ssd_reg  <= {8'd0, ssd_reg[63:8]} + {56'd0, ssd_reg[7:0]};
                    end else begin
                        opa_reg   <= {var_sel, 16'h0000};
                        mode_reg  <= dwzn_pkg::MODE_SQRT;
                        start_reg <= 1'b1;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (stat.done) begin
                        sd_reg <= result[31:0];
                        if (recs_reg > 9'(dwzn_pkg::MAX_BATCH)) begin
                            n_reg    <= 5'(dwzn_pkg::MAX_BATCH);
                            drop_reg <= 1'b1;
                        end else begin
                            n_reg    <= recs_reg[4:0];
                            drop_reg <= 1'b0;
                        end
                        k_reg     <= 5'd0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    pos_reg   <= rec_addr;
                    state_reg <= ST_RDW;
                end
                ST_RDW: begin
                    x_reg     <= rd_data;
                    neg_reg   <= dev[25];
                    opa_reg   <= {20'd0, mag, 19'd0} + {32'd0, sd_reg};
                    opb_reg   <= {1'b0, sd_reg, 1'b0};
                    mode_reg  <= dwzn_pkg::MODE_DIV;
                    start_reg <= 1'b1;
                    state_reg <= ST_ZDIV;
                end
                ST_ZDIV: begin
                    if (stat.done) begin
                        oavg_reg   <= x_reg;
                        oz_reg     <= z_val;
                        opos_reg   <= 8'(pos_reg);
                        olast_reg  <= (k_reg + 5'd1 == n_reg);
                        odrop_reg  <= drop_reg;
                        mvalid_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        if (k_reg + 5'd1 == n_reg) begin
                            recs_reg  <= 9'd0;
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 5'd1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = {7'd0, opos_reg, oz_reg, oavg_reg};
    assign m_tlast    = olast_reg;
    assign m_tuser[0] = odrop_reg;

    // Input and output are never open together: one word is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input accepted while a result word is pending");

    // The shared unit is only started while it is free.
    assert property (@(posedge aclk) disable iff (!aresetn) start_reg |-> !stat.busy)
        else $error("shared unit started while busy");

    // Handing over the final word of a batch clears the batch record count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (recs_reg == 9'd0))
        else $error("batch record count not cleared after final word");

endmodule
